// ===== sv/ovc_pkg.sv =====
package ovc_pkg;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam int CODE_W = 72;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  localparam logic KIND_CODE  = 1'b0;
  localparam logic KIND_VALUE = 1'b1;

  localparam logic [3:0] LEN_ONE  = 4'd1;
  localparam logic [3:0] LEN_LONG = 4'd8;
  localparam logic [3:0] LEN_MAX  = 4'd9;

  typedef struct packed {
    logic               cmd;
    logic signed [63:0] value;
    logic [7:0]         in_byte;
  } ovc_in_t;

  typedef struct packed {
    logic               out_kind;
    logic [7:0]         out_byte;
    logic signed [63:0] out_value;
    logic               last;
  } ovc_out_t;

  // one queued job: encoded bytes left aligned, or a decoded value in the low bits
  typedef struct packed {
    logic              kind;
    logic [3:0]        len;
    logic [CODE_W-1:0] data;
  } ovc_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ovc_qstat_t;

endpackage

// ===== sv/ovc_front.sv =====
module ovc_front import ovc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  ovc_in_t    in_data,
  input  ovc_qstat_t q_stat,
  output logic       q_push,
  output ovc_job_t   q_job
);

  logic [3:0]  seen_r, seen_nxt;
  logic [3:0]  exp_r, exp_nxt;
  logic        sign_r, sign_nxt;
  logic        und_r, und_nxt;
  logic [63:0] acc_r, acc_nxt;

  logic        accept;
  logic        done;

  // encode path
  logic [63:0] neg, ev, enc_w;
  logic [3:0]  nb;
  logic [7:0]  enc_mask;
  logic [6:0]  mask_sh, align_sh;
  logic [CODE_W-1:0] enc_code;

  // decode path
  logic [7:0]  b, x;
  logic        s;
  logic [3:0]  lz;
  logic [63:0] dec_value;

  function automatic logic [63:0] finish_value(input logic [3:0] n, input logic [63:0] acc,
                                               input logic sgn);
    logic [63:0] v;
    logic [63:0] fill;
    logic [7:0]  mb;
    logic [6:0]  sh;
    logic [3:0]  nm1;
    nm1  = n - 4'd1;
    mb   = 8'(16'hFF00 >> n);
    sh   = {nm1[3:0], 3'b000};
    fill = '1 << {n, 3'b000};
    if (n >= LEN_MAX) begin
      v = acc ^ {1'b1, 63'b0};
    end else begin
      v = acc ^ ({56'b0, mb} << sh);
      if (n < LEN_LONG) begin
        if (!sgn) v = v | fill;
        else      v = v & ~fill;
      end
    end
    return v;
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_ready = !q_stat.full;

  always_comb begin
    neg = {64{in_data.value[63]}};
    ev  = in_data.value ^ neg;
    // one more byte for every 7-bit group past the first six bits
    nb  = LEN_ONE;
    for (int k = 1; k <= 8; k++) begin
      if ((ev >> (7 * k - 1)) != 64'd0) nb = nb + 4'd1;
    end
    enc_mask = 8'(16'hFF00 >> nb);
    mask_sh  = {nb - 4'd1, 3'b000};
    align_sh = {LEN_LONG - nb, 3'b000};
    if (nb == LEN_MAX) begin
      enc_w    = (ev | {1'b1, 63'b0}) ^ neg;
      enc_code = {~neg[7:0], enc_w};
    end else begin
      enc_w    = (ev | ({56'b0, enc_mask} << mask_sh)) ^ neg;
      enc_code = {enc_w, 8'h00} << align_sh;
    end
  end

  always_comb begin
    b = in_data.in_byte;
    s = b[7];
    x = b ^ {8{s}};
    lz = 4'd8;
    for (int i = 0; i < 8; i++) begin
      if (x[i]) lz = 4'(7 - i);
    end

    if (seen_r == 4'd0) begin
      seen_nxt = 4'd1;
      exp_nxt  = lz;
      sign_nxt = s;
      und_nxt  = (lz == LEN_LONG);
      acc_nxt  = {56'b0, b};
    end else begin
      seen_nxt = seen_r + 4'd1;
      sign_nxt = sign_r;
      und_nxt  = 1'b0;
      acc_nxt  = {acc_r[55:0], b};
      if (und_r) begin
        // leading 0x00/0xff: second byte's top bit tells 8 from 9 bytes
        exp_nxt = (b[7] == sign_r) ? LEN_MAX : LEN_LONG;
      end else begin
        exp_nxt = exp_r;
      end
    end
    done      = !und_nxt && (seen_nxt >= exp_nxt);
    dec_value = finish_value(exp_nxt, acc_nxt, sign_nxt);
  end

  always_comb begin
    q_push = accept && ((in_data.cmd == CMD_ENCODE) || done);
    if (in_data.cmd == CMD_ENCODE) begin
      q_job.kind = KIND_CODE;
      q_job.len  = nb;
      q_job.data = enc_code;
    end else begin
      q_job.kind = KIND_VALUE;
      q_job.len  = LEN_ONE;
      q_job.data = {8'h00, dec_value};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      exp_r  <= '0;
      sign_r <= 1'b0;
      und_r  <= 1'b0;
      acc_r  <= '0;
    end else if (accept && in_data.cmd == CMD_DECODE) begin
      if (done) begin
        seen_r <= '0;
        exp_r  <= '0;
        sign_r <= 1'b0;
        und_r  <= 1'b0;
        acc_r  <= '0;
      end else begin
        seen_r <= seen_nxt;
        exp_r  <= exp_nxt;
        sign_r <= sign_nxt;
        und_r  <= und_nxt;
        acc_r  <= acc_nxt;
      end
    end
  end

  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= LEN_LONG) else $error("decode byte count out of range");
  a_und_first: assert property (@(posedge clk) disable iff (!rst_n)
    und_r |-> (seen_r == 4'd1)) else $error("undecided length past the second byte");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full) else $error("push into full queue");

endmodule

// ===== sv/ovc_fifo.sv =====
module ovc_fifo import ovc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  ovc_job_t   push_job,
  input  logic       pop,
  output ovc_job_t   head_job,
  output ovc_qstat_t stat
);

  ovc_job_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_r, rd_r;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head_job   = mem_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + Q_CNT_W'(1);
    if (pop && !push) cnt_nxt = cnt_r - Q_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + Q_PTR_W'(1);
      if (pop)  rd_r <= rd_r + Q_PTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= Q_CNT_W'(Q_DEPTH)) else $error("queue count overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty) else $error("pop from empty queue");

endmodule

// ===== sv/ovc_back.sv =====
module ovc_back import ovc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  ovc_job_t   head_job,
  input  ovc_qstat_t q_stat,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output ovc_out_t   out_data
);

  logic              busy_r;
  logic              kind_r;
  logic [3:0]        rem_r;
  logic [CODE_W-1:0] data_r;
  logic              last_word;
  logic              advance;

  assign last_word = (rem_r == LEN_ONE);
  assign advance   = out_valid && out_ready;
  assign q_pop     = !q_stat.empty && (!busy_r || (advance && last_word));
  assign out_valid = busy_r;

  always_comb begin
    out_data.out_kind  = kind_r;
    out_data.out_byte  = (kind_r == KIND_CODE) ? data_r[CODE_W-1 -: 8] : 8'h00;
    out_data.out_value = (kind_r == KIND_VALUE) ? signed'(data_r[63:0]) : 64'sd0;
    out_data.last      = last_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rem_r  <= '0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      rem_r  <= head_job.len;
    end else if (advance) begin
      busy_r <= !last_word;
      rem_r  <= rem_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r <= head_job.kind;
      data_r <= head_job.data;
    end else if (advance) begin
      // next byte of the code moves to the top
      data_r <= {data_r[CODE_W-9:0], 8'h00};
    end
  end

  a_busy_rem: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (rem_r != 4'd0 && rem_r <= LEN_MAX)) else $error("active job with bad count");
  a_value_single: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && kind_r == KIND_VALUE) |-> last_word) else $error("decoded value not single word");

endmodule

// ===== sv/order_preserving_signed_varint_codec.sv =====
// channel | ports                         | word
// --------+-------------------------------+-------------------------------------------
// input   | in_valid, in_ready, in_data   | encode value or one encoded byte to decode
// output  | out_valid, out_ready, out_data| one encoded byte or one decoded int64
//
// an input word is taken every cycle while the 4-entry job queue has room
// encode words leave as 1 to 9 output words, one per cycle from the back end serializer while out_ready is high
// a decoded value is written into the job queue and then loaded into the back end output registers
// before it is offered, when the queue and the back end are idle
// synchronous active-low reset clears decode progress, the queue and the output stage
// output stalls fill the queue; the input stalls only when the queue is full
module order_preserving_signed_varint_codec import ovc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ovc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output ovc_out_t out_data
);

  ovc_qstat_t q_stat;
  ovc_job_t   push_job, head_job;
  logic       q_push, q_pop;

  ovc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  ovc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  ovc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_job  (head_job),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
